// ===== rtl/fli_pkg.sv =====
// shared types, constants and helpers for the fli frame chunk decoder
// no dependencies
package fli_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = 8;
    localparam int CUR_W     = 16;
    localparam int CFG_DIM_W = 13;

    typedef enum logic [1:0] {
        KIND_PAL64 = 2'd0,
        KIND_COPY  = 2'd1,
        KIND_DELTA = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // pixel-run write candidate, already clipped
    typedef struct packed {
        logic             valid;
        logic [11:0]      x;
        logic [11:0]      y;
        logic [7:0]       len;
        logic             use_prev;
    } t_emit;

    // palette write plus frame-start snapshot
    typedef struct packed {
        logic             we;
        logic [PAL_AW-1:0] addr;
        logic [23:0]      rgb;
        logic             snap;
    } t_pal_ctl;

    function automatic logic [CUR_W-1:0] sat_add16(input logic [CUR_W-1:0] a,
                                                   input logic [CUR_W-1:0] b);
        logic [CUR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CUR_W] ? {CUR_W{1'b1}} : s[CUR_W-1:0];
    endfunction

endpackage

// ===== rtl/fli_parse.sv =====
// byte parser: phase machine, counters, cursors and run clipping
// depends on fli_pkg
module fli_parse (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic                      i_mode,
    input  logic [1:0]                i_chunk_kind,
    input  logic                      i_chunk_first,
    input  logic [7:0]                i_data_byte,
    input  logic [fli_pkg::CUR_W-1:0] i_w,
    input  logic [fli_pkg::CUR_W-1:0] i_h,
    output fli_pkg::t_emit            o_emit,
    output fli_pkg::t_pal_ctl         o_pal
);
    import fli_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_C64_NHI, PH_C64_SKIP, PH_C64_COUNT, PH_C64_R, PH_C64_G,
        PH_C64_B, PH_COPY, PH_D_SKIPHI, PH_D_LINESLO, PH_D_LINESHI, PH_D_PKTS,
        PH_D_COL, PH_D_TYPE, PH_D_LIT, PH_D_REP
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_lo, n_lo;
    logic [15:0]      r_pkts, n_pkts;
    logic [8:0]       r_items, n_items;
    logic [7:0]       r_slot, n_slot;
    logic [15:0]      r_prgb, n_prgb;
    logic [CUR_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [15:0]      r_lines, n_lines;

    logic             em_req, em_before;
    logic [CUR_W-1:0] em_x, em_y, room, len_c;
    logic [8:0]       em_len;
    logic [7:0]       b6;

    assign b6 = {i_data_byte[5:0], 2'b00};

    always_comb begin
        logic do_copy, do_epkt, do_eline;
        logic [CUR_W-1:0] cx0, cy0, nx, ny;
        logic [8:0]  it;
        logic [15:0] pk, ln;
        n_phase = r_phase; n_lo = r_lo; n_pkts = r_pkts; n_items = r_items;
        n_slot = r_slot; n_prgb = r_prgb; n_cx = r_cx; n_cy = r_cy; n_lines = r_lines;
        do_copy = 1'b0; do_epkt = 1'b0; do_eline = 1'b0;
        cx0 = r_cx; cy0 = r_cy; nx = '0; ny = '0; it = '0; pk = '0; ln = '0;
        em_req = 1'b0; em_before = 1'b0; em_x = r_cx; em_y = r_cy; em_len = 9'd1;
        o_pal.we = 1'b0; o_pal.addr = r_slot; o_pal.rgb = {r_prgb, b6};
        o_pal.snap = 1'b0;
        if (i_take) begin
            if (i_mode) begin
                o_pal.snap = 1'b1;
                n_phase = PH_IDLE;
            end else if (i_chunk_first) begin
                unique case (t_kind'(i_chunk_kind))
                    KIND_PAL64: begin
                        n_lo = i_data_byte;
                        n_phase = PH_C64_NHI;
                    end
                    KIND_COPY: begin
                        cx0 = '0;
                        cy0 = '0;
                        do_copy = 1'b1;
                    end
                    KIND_DELTA: begin
                        n_lo = i_data_byte;
                        n_phase = PH_D_SKIPHI;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end else begin
                unique case (r_phase)
                    PH_C64_NHI: begin
                        n_pkts = {i_data_byte, r_lo};
                        n_slot = '0;
                        n_phase = ({i_data_byte, r_lo} == 16'd0) ? PH_IDLE : PH_C64_SKIP;
                    end
                    PH_C64_SKIP: begin
                        n_slot = r_slot + i_data_byte;
                        n_phase = PH_C64_COUNT;
                    end
                    PH_C64_COUNT: begin
                        n_items = (i_data_byte == 8'd0) ? 9'd256 : {1'b0, i_data_byte};
                        n_phase = PH_C64_R;
                    end
                    PH_C64_R: begin
                        n_prgb = {b6, 8'd0};
                        n_phase = PH_C64_G;
                    end
                    PH_C64_G: begin
                        n_prgb = {r_prgb[15:8], b6};
                        n_phase = PH_C64_B;
                    end
                    PH_C64_B: begin
                        o_pal.we = 1'b1;
                        n_slot = r_slot + 8'd1;
                        it = r_items - 9'd1;
                        n_items = it;
                        if (it != 9'd0) begin
                            n_phase = PH_C64_R;
                        end else begin
                            pk = r_pkts - 16'd1;
                            n_pkts = pk;
                            n_phase = (pk == 16'd0) ? PH_IDLE : PH_C64_SKIP;
                        end
                    end
                    PH_COPY: do_copy = 1'b1;
                    PH_D_SKIPHI: begin
                        n_cy = {i_data_byte, r_lo};
                        n_phase = PH_D_LINESLO;
                    end
                    PH_D_LINESLO: begin
                        n_lo = i_data_byte;
                        n_phase = PH_D_LINESHI;
                    end
                    PH_D_LINESHI: begin
                        n_lines = {i_data_byte, r_lo};
                        n_phase = ({i_data_byte, r_lo} == 16'd0) ? PH_IDLE : PH_D_PKTS;
                    end
                    PH_D_PKTS: begin
                        n_cx = '0;
                        n_pkts = {8'd0, i_data_byte};
                        if (i_data_byte == 8'd0) do_eline = 1'b1;
                        else n_phase = PH_D_COL;
                    end
                    PH_D_COL: begin
                        n_cx = sat_add16(r_cx, {8'd0, i_data_byte});
                        n_phase = PH_D_TYPE;
                    end
                    PH_D_TYPE: begin
                        if (i_data_byte == 8'd0) begin
                            do_epkt = 1'b1;
                        end else if (!i_data_byte[7]) begin
                            n_items = {1'b0, i_data_byte};
                            n_phase = PH_D_LIT;
                        end else begin
                            // minus 128 comes out as 128 repeats
                            n_items = 9'd256 - {1'b0, i_data_byte};
                            n_phase = PH_D_REP;
                        end
                    end
                    PH_D_LIT: begin
                        em_req = 1'b1;
                        em_before = 1'b1;
                        n_cx = sat_add16(r_cx, 16'd1);
                        it = r_items - 9'd1;
                        n_items = it;
                        if (it == 9'd0) do_epkt = 1'b1;
                    end
                    PH_D_REP: begin
                        em_req = 1'b1;
                        em_before = 1'b1;
                        em_len = r_items;
                        n_cx = sat_add16(r_cx, {7'd0, r_items});
                        n_items = '0;
                        do_epkt = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        if (do_copy) begin
            em_req = 1'b1;
            em_x = cx0;
            em_y = cy0;
            nx = sat_add16(cx0, 16'd1);
            ny = cy0;
            if (nx >= i_w) begin
                nx = '0;
                ny = sat_add16(cy0, 16'd1);
            end
            n_cx = nx;
            n_cy = ny;
            n_phase = (ny >= i_h) ? PH_IDLE : PH_COPY;
        end
        if (do_epkt) begin
            pk = r_pkts - 16'd1;
            n_pkts = pk;
            if (pk == 16'd0) do_eline = 1'b1;
            else n_phase = PH_D_COL;
        end
        if (do_eline) begin
            ln = r_lines - 16'd1;
            n_lines = ln;
            n_cy = sat_add16(r_cy, 16'd1);
            n_phase = (ln == 16'd0) ? PH_IDLE : PH_D_PKTS;
        end
    end

    // clip at the right edge, drop writes that start outside
    assign room  = i_w - em_x;
    assign len_c = ({7'd0, em_len} > room) ? room : {7'd0, em_len};

    always_comb begin
        o_emit.valid    = em_req && (em_x < i_w) && (em_y < i_h) && (em_len != 9'd0);
        o_emit.x        = em_x[11:0];
        o_emit.y        = em_y[11:0];
        o_emit.len      = len_c[7:0];
        o_emit.use_prev = em_before;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lo    <= '0;
            r_pkts  <= '0;
            r_items <= '0;
            r_slot  <= '0;
            r_prgb  <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_lines <= '0;
        end else begin
            r_phase <= n_phase;
            r_lo    <= n_lo;
            r_pkts  <= n_pkts;
            r_items <= n_items;
            r_slot  <= n_slot;
            r_prgb  <= n_prgb;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_lines <= n_lines;
        end
    end

endmodule

// ===== rtl/fli_pal.sv =====
// double palette: two banks with per-entry ownership bits, snapshot by copying the ownership bits
// depends on fli_pkg
module fli_pal (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fli_pkg::t_pal_ctl          i_ctl,
    input  logic                       i_re,
    input  logic [fli_pkg::PAL_AW-1:0] i_raddr,
    input  logic                       i_before,
    output logic                       o_busy,
    output logic [23:0]                o_rgb
);
    import fli_pkg::*;

    logic [23:0]          bank0 [PAL_DEPTH];
    logic [23:0]          bank1 [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] r_cur, r_prv;
    logic [23:0]          r_q0, r_q1;
    logic                 r_sel;
    logic                 r_clr;
    logic [PAL_AW-1:0]    r_clr_addr;
    logic                 wbank;

    // the current entry never overwrites the bank that holds the snapshot
    assign wbank = (r_cur[i_ctl.addr] == r_prv[i_ctl.addr]) ? ~r_prv[i_ctl.addr]
                                                            : r_cur[i_ctl.addr];

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            // zero both banks one entry per cycle after reset
            bank0[r_clr_addr] <= '0;
            bank1[r_clr_addr] <= '0;
        end else begin
            if (i_ctl.we && !wbank) bank0[i_ctl.addr] <= i_ctl.rgb;
            if (i_ctl.we && wbank)  bank1[i_ctl.addr] <= i_ctl.rgb;
        end
        if (i_re) begin
            r_q0 <= bank0[i_raddr];
            r_q1 <= bank1[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_prv      <= '0;
            r_sel      <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + PAL_AW'(1);
                if (r_clr_addr == PAL_AW'(PAL_DEPTH - 1)) r_clr <= 1'b0;
            end
            if (i_ctl.we) r_cur[i_ctl.addr] <= wbank;
            if (i_ctl.snap) r_prv <= r_cur;
            if (i_re) r_sel <= i_before ? r_prv[i_raddr] : r_cur[i_raddr];
        end
    end

    assign o_busy = r_clr;
    assign o_rgb  = r_sel ? r_q1 : r_q0;

endmodule

// ===== rtl/fli_frame_chunk_decoder_core.sv =====
// top level of the fli frame chunk decoder: config, pipeline and output register
// depends on fli_pkg, fli_parse, fli_pal
//
// takes one chunk byte (or frame-start mark) per cycle and gives at most one
// pixel-run write per byte; it sits in stage 1 and then the output register after
// its byte transfer. sustained rate is one byte per clock while the output side
// does not stall. the parser works on each byte in the cycle it arrives; the
// palette lookup uses a registered memory read, so results pass through one middle
// stage and then the output register. the whole pipe holds while the output
// register is full and stalled. two palette banks plus per-entry ownership bits
// let a frame start snapshot all 256 entries by copying the ownership bits. after
// reset a clearing pass zeroes both banks one entry at a time, and the input is
// stalled until it ends. frame_width and frame_height are clamped to 1..MAX_DIM;
// write them only while no byte is in flight.
module fli_frame_chunk_decoder_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [fli_pkg::CFG_DIM_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [1:0]                    i_chunk_kind,
    input  logic                          i_chunk_first,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [11:0]                   o_pixel_x,
    output logic [11:0]                   o_pixel_y,
    output logic [7:0]                    o_run_length,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue
);
    import fli_pkg::*;

    localparam logic [CUR_W-1:0] DimMax = CUR_W'(MAX_DIM);

    logic [CFG_DIM_W-1:0] r_fw, r_fh;
    logic [CUR_W-1:0]     eff_w, eff_h;
    logic                 adv, take;
    logic                 pal_busy;
    t_emit                emit;
    t_pal_ctl             pal_ctl;
    logic [23:0]          pal_rgb;

    // stage 1 holds the write while the palette read completes
    logic        r_s1_valid;
    logic [11:0] r_s1_x, r_s1_y;
    logic [7:0]  r_s1_len;

    function automatic logic [CUR_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [CUR_W-1:0] e;
        e = CUR_W'(v);
        if (e == '0) return CUR_W'(1);
        if (e > DimMax) return DimMax;
        return e;
    endfunction

    assign eff_w = clamp_dim(r_fw);
    assign eff_h = clamp_dim(r_fh);

    // pipe holds only when the output register is full and stalled
    assign adv        = !(o_out_valid && i_out_stall);
    // no transfer while the palette is being cleared
    assign o_in_stall = !adv || pal_busy;
    assign take       = i_in_valid && adv && !pal_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= CFG_DIM_W'(320);
            r_fh <= CFG_DIM_W'(200);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_fw <= i_cfg_data;
                CFG_HEIGHT: r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fli_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_mode        (i_mode),
        .i_chunk_kind  (i_chunk_kind),
        .i_chunk_first (i_chunk_first),
        .i_data_byte   (i_data_byte),
        .i_w           (eff_w),
        .i_h           (eff_h),
        .o_emit        (emit),
        .o_pal         (pal_ctl)
    );

    fli_pal u_pal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (pal_ctl),
        .i_re     (adv),
        .i_raddr  (i_data_byte),
        .i_before (emit.use_prev),
        .o_busy   (pal_busy),
        .o_rgb    (pal_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= emit.valid;
            o_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_x       <= emit.x;
            r_s1_y       <= emit.y;
            r_s1_len     <= emit.len;
            o_pixel_x    <= r_s1_x;
            o_pixel_y    <= r_s1_y;
            o_run_length <= r_s1_len;
            o_red        <= pal_rgb[23:16];
            o_green      <= pal_rgb[15:8];
            o_blue       <= pal_rgb[7:0];
        end
    end

`ifndef NO_ASSERTIONS
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv) |=> o_out_valid)
        else $error("stage 1 write lost on its way to the output");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_length != 8'd0))
        else $error("run write with zero length");

    a_s1_from_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.valid && !take) |-> 1'b0)
        else $error("write raised without a byte transfer");
`endif

endmodule
